>>> hw/rtl/vdie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex dedup package
// Shared types, constants, state codes and the zero-folding and NaN helpers of the engine.
// ----------------------------------------------------------------------------
package vdie_pkg;

    localparam int MAX_VERTICES_DEF = 4096;
    localparam int MAX_UNIQUE_DEF   = 4096;
    localparam int HASH_SLOTS_DEF   = 8192;
    localparam int IDX_W            = 12;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_REMAP = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_UNSEEN = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [31:0]      x_bits;
        logic [31:0]      y_bits;
        logic [31:0]      z_bits;
        logic [IDX_W-1:0] corner_vertex;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] unique_index;
        logic             is_new;
        logic [1:0]       status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WIPE,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_HASH4,
        S_PREAD,
        S_PWAIT,
        S_PCHK,
        S_KWAIT,
        S_KCHK,
        S_MREAD,
        S_MWAIT,
        S_RESP
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_req;
        logic wipe_start;
        logic wipe_step;
        logic hash_step;
        logic probe_init;
        logic slot_read;
        logic key_read;
        logic probe_next;
        logic commit_match;
        logic commit_new;
        logic map_read;
        logic rsp_set;
        logic [1:0] rsp_status;
        logic rsp_from_map;
        logic counters_clear;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic    wipe_last;
        logic    slot_valid;
        logic    slot_idx_ok;
        logic    key_equal;
        logic    probe_exhausted;
        logic    vcount_full;
        logic    ucount_full;
        logic    corner_ok;
        logic [1:0] mode;
    } stat_t;

    function automatic logic [31:0] canon32(input logic [31:0] b);
        canon32 = (b[30:0] == 31'd0) ? 32'd0 : b;
    endfunction

    function automatic logic is_nan32(input logic [31:0] b);
        is_nan32 = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/vdie_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex dedup controller
// Sequences hashing, probing, commit and response for one request.
// ----------------------------------------------------------------------------
module vdie_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    output vdie_pkg::cmd_t      cmd,
    input  wire vdie_pkg::stat_t stat
);

    vdie_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vdie_pkg::S_WIPE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.rsp_status = vdie_pkg::ST_OK;
        unique case (state_reg)
            vdie_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = vdie_pkg::S_HASH1;
                end
            end
            vdie_pkg::S_WIPE: begin
                cmd.wipe_step = 1'b1;
                if (stat.wipe_last) begin
                    state_next = vdie_pkg::S_IDLE;
                end
            end
            vdie_pkg::S_HASH1: begin
                unique case (stat.mode)
                    vdie_pkg::MODE_ADD: begin
                        cmd.hash_step = 1'b1;
                        if (stat.vcount_full) begin
                            cmd.rsp_set    = 1'b1;
                            cmd.rsp_status = vdie_pkg::ST_FULL;
                            state_next     = vdie_pkg::S_RESP;
                        end else begin
                            state_next = vdie_pkg::S_HASH2;
                        end
                    end
                    vdie_pkg::MODE_REMAP: begin
                        if (stat.corner_ok) begin
                            cmd.map_read = 1'b1;
                            state_next   = vdie_pkg::S_MREAD;
                        end else begin
                            cmd.rsp_set    = 1'b1;
                            cmd.rsp_status = vdie_pkg::ST_UNSEEN;
                            state_next     = vdie_pkg::S_RESP;
                        end
                    end
                    vdie_pkg::MODE_CLEAR: begin
                        // The response goes out first; the sweep follows it.
                        cmd.rsp_set        = 1'b1;
                        cmd.counters_clear = 1'b1;
                        cmd.wipe_start     = 1'b1;
                        state_next         = vdie_pkg::S_RESP;
                    end
                    default: begin
                        cmd.rsp_set = 1'b1;
                        state_next  = vdie_pkg::S_RESP;
                    end
                endcase
            end
            vdie_pkg::S_HASH2: begin
                cmd.hash_step = 1'b1;
                state_next    = vdie_pkg::S_HASH3;
            end
            vdie_pkg::S_HASH3: begin
                cmd.hash_step = 1'b1;
                state_next    = vdie_pkg::S_HASH4;
            end
            vdie_pkg::S_HASH4: begin
                cmd.hash_step  = 1'b1;
                cmd.probe_init = 1'b1;
                state_next     = vdie_pkg::S_PREAD;
            end
            vdie_pkg::S_PREAD: begin
                cmd.slot_read = 1'b1;
                state_next    = vdie_pkg::S_PWAIT;
            end
            vdie_pkg::S_PWAIT: begin
                state_next = vdie_pkg::S_PCHK;
            end
            vdie_pkg::S_PCHK: begin
                if (!stat.slot_valid) begin
                    cmd.rsp_set = 1'b1;
                    if (stat.ucount_full) begin
                        cmd.rsp_status = vdie_pkg::ST_FULL;
                    end else begin
                        cmd.commit_new = 1'b1;
                    end
                    state_next = vdie_pkg::S_RESP;
                end else if (stat.slot_idx_ok) begin
                    cmd.key_read = 1'b1;
                    state_next   = vdie_pkg::S_KWAIT;
                end else if (stat.probe_exhausted) begin
                    cmd.rsp_set    = 1'b1;
                    cmd.rsp_status = vdie_pkg::ST_FULL;
                    state_next     = vdie_pkg::S_RESP;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = vdie_pkg::S_PREAD;
                end
            end
            vdie_pkg::S_KWAIT: begin
                state_next = vdie_pkg::S_KCHK;
            end
            vdie_pkg::S_KCHK: begin
                if (stat.key_equal) begin
                    cmd.rsp_set      = 1'b1;
                    cmd.commit_match = 1'b1;
                    state_next       = vdie_pkg::S_RESP;
                end else if (stat.probe_exhausted) begin
                    cmd.rsp_set    = 1'b1;
                    cmd.rsp_status = vdie_pkg::ST_FULL;
                    state_next     = vdie_pkg::S_RESP;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = vdie_pkg::S_PREAD;
                end
            end
            vdie_pkg::S_MREAD: begin
                state_next = vdie_pkg::S_MWAIT;
            end
            vdie_pkg::S_MWAIT: begin
                cmd.rsp_set      = 1'b1;
                cmd.rsp_from_map = 1'b1;
                state_next       = vdie_pkg::S_RESP;
            end
            vdie_pkg::S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (stat.mode == vdie_pkg::MODE_CLEAR) begin
                        state_next = vdie_pkg::S_WIPE;
                    end else begin
                        state_next = vdie_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = vdie_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/vdie_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex dedup datapath
// Hash pipeline, slot and key memories, vertex map and counters.
// ----------------------------------------------------------------------------
module vdie_dp #(
    parameter int MAX_VERTICES = vdie_pkg::MAX_VERTICES_DEF,
    parameter int MAX_UNIQUE   = vdie_pkg::MAX_UNIQUE_DEF,
    parameter int HASH_SLOTS   = vdie_pkg::HASH_SLOTS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire vdie_pkg::req_t  s_req,
    input  wire vdie_pkg::cmd_t  cmd,
    output vdie_pkg::stat_t      stat,
    output vdie_pkg::rsp_t       m_rsp
);

    localparam int SW = $clog2(HASH_SLOTS);
    localparam int UW = $clog2(MAX_UNIQUE);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int UCW = UW + 1;
    localparam int VCW = VW + 1;
    localparam int SCW = SW + 1;

    // Request registers.
    vdie_pkg::req_t req_reg;

    // Hash pipeline registers.
    logic [31:0] hx_reg, hy_reg, hz_reg, h_reg;
    logic [1:0]  hstep_reg;

    // Probe state.
    logic [SW-1:0]  pos_reg;
    logic [SCW-1:0] probes_reg;

    // Memories.
    logic            slot_vld_mem [HASH_SLOTS];
    logic [UW-1:0]   slot_uni_mem [HASH_SLOTS];
    logic [95:0]     key_mem      [MAX_UNIQUE];
    logic [UW-1:0]   map_mem      [MAX_VERTICES];

    logic            slot_vld_q;
    logic [UW-1:0]   slot_uni_q;
    logic [95:0]     key_q;
    logic [UW-1:0]   map_q;

    // Wipe sweep over the slot valid store.
    logic [SW-1:0]   wipe_reg;

    logic [UCW-1:0]  ucount_reg;
    logic [VCW-1:0]  vcount_reg;
    vdie_pkg::rsp_t  rsp_reg;

    logic [31:0] cx, cy, cz;
    assign cx = vdie_pkg::canon32(req_reg.x_bits);
    assign cy = vdie_pkg::canon32(req_reg.y_bits);
    assign cz = vdie_pkg::canon32(req_reg.z_bits);

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_req;
        end
    end

    // Hash: products are registered, then folded over three more steps.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            hstep_reg <= 2'd0;
        end else if (cmd.hash_step) begin
            hstep_reg <= hstep_reg + 2'd1;
            case (hstep_reg)
                2'd0: begin
                    hx_reg <= cx * 32'h9E3779B1;
                    hy_reg <= cy * 32'h85EBCA77;
                    hz_reg <= cz * 32'hC2B2AE3D;
                end
                2'd1: begin
                    h_reg <= (hx_reg ^ hy_reg ^ hz_reg)
                             ^ ((hx_reg ^ hy_reg ^ hz_reg) >> 15);
                end
                2'd2: begin
                    h_reg <= h_reg * 32'h2C1B3C6D;
                end
                default: begin
                    h_reg <= h_reg ^ (h_reg >> 13);
                end
            endcase
        end
    end

    logic [31:0]   hfin;
    logic [SW-1:0] hlow;
    logic [SW-1:0] hmod;
    assign hfin = h_reg ^ (h_reg >> 13);
    // The low bits lie below twice the slot count, so one subtraction
    // brings them into range.
    assign hlow = hfin[SW-1:0];
    assign hmod = (32'(hlow) >= HASH_SLOTS) ? hlow - SW'(HASH_SLOTS) : hlow;

    always_ff @(posedge aclk) begin
        if (cmd.probe_init) begin
            pos_reg    <= hmod;
            probes_reg <= SCW'(1);
        end else if (cmd.probe_next) begin
            pos_reg    <= (32'(pos_reg) == HASH_SLOTS - 1) ? '0 : pos_reg + SW'(1);
            probes_reg <= probes_reg + SCW'(1);
        end
    end

    // Slot memories.
    always_ff @(posedge aclk) begin
        if (cmd.wipe_step) begin
            slot_vld_mem[wipe_reg] <= 1'b0;
        end else if (cmd.commit_new) begin
            slot_vld_mem[pos_reg] <= 1'b1;
        end
        if (cmd.slot_read) begin
            slot_vld_q <= slot_vld_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit_new) begin
            slot_uni_mem[pos_reg] <= ucount_reg[UW-1:0];
        end
        if (cmd.slot_read) begin
            slot_uni_q <= slot_uni_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit_new) begin
            key_mem[ucount_reg[UW-1:0]] <= {req_reg.x_bits, req_reg.y_bits, req_reg.z_bits};
        end
        if (cmd.key_read) begin
            key_q <= key_mem[slot_uni_q];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit_new) begin
            map_mem[vcount_reg[VW-1:0]] <= ucount_reg[UW-1:0];
        end else if (cmd.commit_match) begin
            map_mem[vcount_reg[VW-1:0]] <= slot_uni_q;
        end
        if (cmd.map_read) begin
            map_q <= map_mem[req_reg.corner_vertex[VW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wipe_reg <= '0;
        end else if (cmd.wipe_start) begin
            wipe_reg <= '0;
        end else if (cmd.wipe_step) begin
            wipe_reg <= wipe_reg + SW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.counters_clear) begin
            ucount_reg <= '0;
            vcount_reg <= '0;
        end else begin
            if (cmd.commit_new) begin
                ucount_reg <= ucount_reg + UCW'(1);
            end
            if (cmd.commit_new || cmd.commit_match) begin
                vcount_reg <= vcount_reg + VCW'(1);
            end
        end
    end

    logic [vdie_pkg::IDX_W-1:0] idx_new, idx_match, idx_map;
    assign idx_new   = vdie_pkg::IDX_W'(ucount_reg[UW-1:0]);
    assign idx_match = vdie_pkg::IDX_W'(slot_uni_q);
    assign idx_map   = vdie_pkg::IDX_W'(map_q);

    always_ff @(posedge aclk) begin
        if (cmd.rsp_set) begin
            rsp_reg.status <= cmd.rsp_status;
            rsp_reg.is_new <= cmd.commit_new;
            if (cmd.commit_new) begin
                rsp_reg.unique_index <= idx_new;
            end else if (cmd.commit_match) begin
                rsp_reg.unique_index <= idx_match;
            end else if (cmd.rsp_from_map) begin
                rsp_reg.unique_index <= idx_map;
            end else begin
                rsp_reg.unique_index <= '0;
            end
        end
    end
    assign m_rsp = rsp_reg;

    logic [31:0] kx, ky, kz;
    assign kx = key_q[95:64];
    assign ky = key_q[63:32];
    assign kz = key_q[31:0];

    always_comb begin
        stat.wipe_last   = (32'(wipe_reg) == HASH_SLOTS - 1);
        stat.slot_valid  = slot_vld_q;
        stat.slot_idx_ok = (UCW'(slot_uni_q) < ucount_reg);
        stat.key_equal   = !vdie_pkg::is_nan32(kx) && !vdie_pkg::is_nan32(req_reg.x_bits)
                        && !vdie_pkg::is_nan32(ky) && !vdie_pkg::is_nan32(req_reg.y_bits)
                        && !vdie_pkg::is_nan32(kz) && !vdie_pkg::is_nan32(req_reg.z_bits)
                        && (vdie_pkg::canon32(kx) == cx)
                        && (vdie_pkg::canon32(ky) == cy)
                        && (vdie_pkg::canon32(kz) == cz);
        stat.probe_exhausted = (32'(probes_reg) >= HASH_SLOTS);
        stat.vcount_full = (32'(vcount_reg) >= MAX_VERTICES);
        stat.ucount_full = (32'(ucount_reg) >= MAX_UNIQUE);
        stat.corner_ok   = (32'(req_reg.corner_vertex) < 32'(vcount_reg))
                        && (32'(req_reg.corner_vertex) < MAX_VERTICES);
        stat.mode        = req_reg.mode;
    end

endmodule
`default_nettype wire

>>> hw/rtl/vertex_dedup_index_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex dedup index engine
// Exact-match vertex welding with an open-addressed hash store.
// ----------------------------------------------------------------------------
// Usage. One request enters on the s_ channel (valid/ready) and exactly one
// response leaves on the m_ channel. Mode 0 adds a vertex and returns its
// dense index with is_new; mode 1 remaps a face corner to its unique index;
// mode 2 clears the store and counters; mode 3 returns an all-zero response.
// The block handles one request at a time. An add vertex request passes
// the hash states, then a read, a wait and a check state for each probed
// slot and a wait and a check state for each key compare, the slot and key
// memories being read in turn; the response register is loaded in the last
// check state. A remap with a valid corner first reads the vertex map; other
// modes answer from the first hash state. s_ready rises in the cycle after
// the response is taken. After reset, and after the response to every clear
// request, the slot valid store is swept one slot a cycle, over all HASH_SLOTS
// slots (8192 by default), while s_ready is low. The response is held in a
// register; while the receiver stalls, m_valid stays high and no new request
// is taken.
// ----------------------------------------------------------------------------
module vertex_dedup_index_engine #(
    parameter int MAX_VERTICES = vdie_pkg::MAX_VERTICES_DEF,
    parameter int MAX_UNIQUE   = vdie_pkg::MAX_UNIQUE_DEF,
    parameter int HASH_SLOTS   = vdie_pkg::HASH_SLOTS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire vdie_pkg::req_t  s_payload,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output vdie_pkg::rsp_t       m_payload
);

    vdie_pkg::cmd_t  cmd;
    vdie_pkg::stat_t stat;

    // The controller only sequences; all storage lives in the datapath.
    vdie_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    vdie_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_UNIQUE   (MAX_UNIQUE),
        .HASH_SLOTS   (HASH_SLOTS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_payload),
        .cmd     (cmd),
        .stat    (stat),
        .m_rsp   (m_payload)
    );

endmodule
`default_nettype wire

>>> hw/rtl/vdie_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex dedup port checker
// Port-level checks on the engine, attached by bind.
// ----------------------------------------------------------------------------
module vdie_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire vdie_pkg::rsp_t m_payload
);

    // One request at a time: no new request while a response is offered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request taken during response");

    // A response is never new and in error at once.
    a_new_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.is_new) |-> (m_payload.status == vdie_pkg::ST_OK))
        else $error("new vertex with bad status");

    // An accepted request is never answered in the next cycle.
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("response too early");

    // Response held while stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("response dropped while stalled");

endmodule

bind vertex_dedup_index_engine vdie_checker u_vdie_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex dedup index engine testbench
// Sends vertex, corner-remap, clear and unused-mode requests, predicts every
// response from a behavioural copy of the welding rules, and compares each
// response field by field under random idling and back-pressure on both
// channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_VERTS = 4096;
    localparam int NUM_UNIQ  = 4096;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    vdie_pkg::req_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    vdie_pkg::rsp_t m_payload;

    vertex_dedup_index_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // The clock runs with a 4 ns period for the whole run.
    initial begin
        forever #2 aclk = ~aclk;
    end

    // A generous fixed limit: clearing sweeps, a full vertex table and
    // heavy stalls together stay far below this.
    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Idling percentages for each side, and a counted receiver hold-off.
    int tx_idle = 0;
    int rx_idle = 0;
    int rx_hold = 0;
    int failures = 0;

    // Responses still owed by the engine, oldest first.
    vdie_pkg::rsp_t owed_rsp[$];

    // Behavioural copy of the engine's state. Unique vertices are kept in an
    // associative array keyed by their canonical coordinates, since the hash
    // layout never changes which index a vertex receives.
    int          weld_index[bit [95:0]];
    bit [11:0]   corner_map[NUM_VERTS];
    int          vert_total;
    int          uniq_total;

    function automatic bit [31:0] fold_zero(input bit [31:0] b);
        return (b[30:0] == 31'd0) ? 32'd0 : b;
    endfunction

    function automatic bit nan_bits(input bit [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic void wipe_mesh();
        weld_index.delete();
        vert_total = 0;
        uniq_total = 0;
    endfunction

    // Works out the response to one request and advances the mesh state.
    function automatic vdie_pkg::rsp_t weld_request(input vdie_pkg::req_t r);
        vdie_pkg::rsp_t o;
        bit [95:0]      key;
        bit             has_nan;
        o = '0;
        o.status = vdie_pkg::ST_OK;
        case (vdie_pkg::mode_t'(r.mode))
            vdie_pkg::MODE_ADD: begin
                has_nan = nan_bits(r.x_bits) || nan_bits(r.y_bits) || nan_bits(r.z_bits);
                key = {fold_zero(r.x_bits), fold_zero(r.y_bits), fold_zero(r.z_bits)};
                if (vert_total >= NUM_VERTS) begin
                    o.status = vdie_pkg::ST_FULL;
                end else if (!has_nan && weld_index.exists(key)) begin
                    o.unique_index = 12'(weld_index[key]);
                    corner_map[vert_total] = 12'(weld_index[key]);
                    vert_total++;
                end else if (uniq_total >= NUM_UNIQ) begin
                    o.status = vdie_pkg::ST_FULL;
                end else begin
                    // A vertex holding a NaN gets a fresh index and can never
                    // be matched later, so it is not entered in the lookup.
                    if (!has_nan) weld_index[key] = uniq_total;
                    o.unique_index = 12'(uniq_total);
                    o.is_new = 1'b1;
                    corner_map[vert_total] = 12'(uniq_total);
                    uniq_total++;
                    vert_total++;
                end
            end
            vdie_pkg::MODE_REMAP: begin
                if (r.corner_vertex < vert_total) o.unique_index = corner_map[r.corner_vertex];
                else o.status = vdie_pkg::ST_UNSEEN;
            end
            vdie_pkg::MODE_CLEAR: wipe_mesh();
            default: ;
        endcase
        return o;
    endfunction

    // Sends one request: it may idle first, then holds valid until the
    // engine accepts the request. Valid is left high so that a following
    // request can go out on the very next cycle.
    task automatic send_request(input vdie_pkg::req_t r);
        if ($urandom_range(0, 99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < tx_idle) @(posedge aclk);
        end
        owed_rsp.push_back(weld_request(r));
        s_valid   <= 1'b1;
        s_payload <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stops sending and waits until every owed response has come back, plus
    // a margin for work still under way.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (owed_rsp.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic vdie_pkg::req_t make_req(input vdie_pkg::mode_t m,
                                                input bit [31:0] x, input bit [31:0] y,
                                                input bit [31:0] z, input bit [11:0] c);
        vdie_pkg::req_t r;
        r.mode = m;
        r.x_bits = x;
        r.y_bits = y;
        r.z_bits = z;
        r.corner_vertex = c;
        return r;
    endfunction

    // Receiver side: random stalls, or a counted hold-off when one is asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // Response checker: each accepted response against the oldest owed one.
    always @(posedge aclk) begin
        vdie_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_rsp.size() == 0) begin
                $error("unexpected response %p", m_payload);
                failures++;
            end else begin
                want = owed_rsp.pop_front();
                if (m_payload.unique_index !== want.unique_index) begin
                    $error("unique_index: expected %0d, got %0d",
                           want.unique_index, m_payload.unique_index);
                    failures++;
                end
                if (m_payload.is_new !== want.is_new) begin
                    $error("is_new: expected %0d, got %0d", want.is_new, m_payload.is_new);
                    failures++;
                end
                if (m_payload.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_payload.status);
                    failures++;
                end
            end
        end
    end

    // Signed zeros, NaNs, infinities and the largest finite values, with a
    // request that has its unused fields fully set.
    task automatic test_special_values();
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h0, 32'h0, 32'h0, 12'hFFF));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h8000_0000, 32'h0, 32'h8000_0000,
                              12'h0));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h7FC0_0000, 32'h0, 32'h0, 12'h0));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h7FC0_0000, 32'h0, 32'h0, 12'h0));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 12'h0));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h7F80_0000, 32'hFF80_0000,
                              32'h7F7F_FFFF, 12'h0));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h7F80_0000, 32'hFF80_0000,
                              32'h7F7F_FFFF, 12'hABC));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h0000_0001, 32'h8000_0001,
                              32'hFF7F_FFFF, 12'h0));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'h0, 32'h0, 12'h0));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h0, 32'h8000_0000, 32'h0, 12'h0));
    endtask

    // Corner remaps at both ends of the range, the unused mode and clearing.
    task automatic test_remap_and_clear();
        send_request(make_req(vdie_pkg::MODE_REMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 12'd0));
        send_request(make_req(vdie_pkg::MODE_REMAP, 32'h0, 32'h0, 32'h0,
                              12'(vert_total - 1)));
        send_request(make_req(vdie_pkg::MODE_REMAP, 32'h0, 32'h0, 32'h0, 12'(vert_total)));
        send_request(make_req(vdie_pkg::MODE_REMAP, 32'h0, 32'h0, 32'h0, 12'hFFF));
        send_request(make_req(vdie_pkg::MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 12'hFFF));
        send_request(make_req(vdie_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 12'hFFF));
        send_request(make_req(vdie_pkg::MODE_REMAP, 32'h0, 32'h0, 32'h0, 12'd0));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h3F80_0000, 32'h4000_0000,
                              32'h4040_0000, 12'h0));
        send_request(make_req(vdie_pkg::MODE_REMAP, 32'h0, 32'h0, 32'h0, 12'd0));
    endtask

    // Fills the vertex table to its limit with a mix of repeated and fresh
    // vertices, then checks that further vertices, a repeated one among them,
    // are refused while a last-corner remap still behaves.
    task automatic test_table_full();
        bit [31:0] v;
        send_request(make_req(vdie_pkg::MODE_CLEAR, 32'h0, 32'h0, 32'h0, 12'h0));
        while (vert_total < NUM_VERTS) begin
            v = $urandom_range(0, 2999);
            send_request(make_req(vdie_pkg::MODE_ADD, v, ~v, v ^ 32'h5555_5555, 12'h0));
        end
        send_request(make_req(vdie_pkg::MODE_ADD, 32'h1234_5678, 32'h9ABC_DEF0,
                              32'h0F0F_0F0F, 12'h0));
        send_request(make_req(vdie_pkg::MODE_ADD, 32'd7, ~32'd7, 32'd7 ^ 32'h5555_5555,
                              12'h0));
        send_request(make_req(vdie_pkg::MODE_REMAP, 32'h0, 32'h0, 32'h0, 12'hFFF));
        send_request(make_req(vdie_pkg::MODE_CLEAR, 32'h0, 32'h0, 32'h0, 12'h0));
        settle();
    endtask

    // Random mesh traffic: mostly vertices from a small pool so that many
    // repeat, remaps of corners already seen, and some noise.
    task automatic test_random_mesh(input int count);
        bit [31:0] pool[48][3];
        bit [31:0] specials[8] = '{32'h0, 32'h8000_0000, 32'h7FC0_0001, 32'hFFFF_FFFF,
                                   32'h7F80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h0000_0001};
        int             pick;
        vdie_pkg::req_t r;
        for (int i = 0; i < 48; i++) begin
            for (int k = 0; k < 3; k++) begin
                pool[i][k] = ($urandom_range(0, 2) == 0) ? specials[$urandom_range(0, 7)]
                                                          : $urandom();
            end
        end
        for (int n = 0; n < count; n++) begin
            r = make_req(vdie_pkg::MODE_ADD, $urandom(), $urandom(), $urandom(),
                         12'($urandom()));
            pick = $urandom_range(0, 999);
            if (pick < 600) begin
                if ($urandom_range(0, 9) < 7) begin
                    pick = $urandom_range(0, 47);
                    r.x_bits = pool[pick][0];
                    r.y_bits = pool[pick][1];
                    r.z_bits = pool[pick][2];
                    // Sometimes flip the sign of a zero to hit the folded match.
                    if (r.x_bits[30:0] == 31'd0) r.x_bits[31] = 1'($urandom_range(0, 1));
                end
            end else if (pick < 960) begin
                r.mode = vdie_pkg::MODE_REMAP;
                if (vert_total > 0 && $urandom_range(0, 9) < 8)
                    r.corner_vertex = 12'($urandom_range(0, vert_total - 1));
            end else if (pick < 997) begin
                r.mode = vdie_pkg::MODE_NONE;
            end else begin
                r.mode = vdie_pkg::MODE_CLEAR;
            end
            send_request(r);
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // then the sender pauses until everything is answered.
    task automatic test_backpressure();
        tx_idle = 0;
        rx_idle = 0;
        rx_hold = 400;
        for (int i = 0; i < 12; i++) begin
            send_request(make_req(vdie_pkg::MODE_ADD, 32'($urandom_range(0, 3)), 32'h0,
                                  32'h0, 12'h0));
        end
        settle();
    endtask

    initial begin
        wipe_mesh();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_special_values();
        test_remap_and_clear();
        settle();
        test_backpressure();

        tx_idle = 11;
        rx_idle = 84;
        test_random_mesh(500);
        tx_idle = 84;
        rx_idle = 11;
        test_random_mesh(500);
        tx_idle = 0;
        rx_idle = 0;
        test_random_mesh(500);
        settle();

        test_table_full();

        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
